@@ rtl/core/tas_pkg.sv @@
`default_nettype none

package tas_pkg;

    // CORDIC step count, limited to the length of the arctangent table
    localparam int CordicSteps = 16;
    localparam int TableLen    = 24;
    localparam int StepsEff    = (CordicSteps > TableLen) ? TableLen : CordicSteps;

    // +-90 degrees with 16 fraction bits, and the same in Q7.8
    localparam int AngleLimit = 5898240;
    localparam int OutLimit   = 23040;

    // register indexes on the configuration port
    localparam logic CFG_ALPHA = 1'b0;
    localparam logic CFG_TOL   = 1'b1;

    // one input beat
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in;

    // one result beat
    typedef struct packed {
        logic signed [15:0] raw_pitch;
        logic signed [15:0] smoothed_pitch;
        logic               level_flag;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_ROUND,
        ST_CORDIC,
        ST_ANGLE,
        ST_MULT,
        ST_ACCUM,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic square;
        logic sqrt_init;
        logic sqrt_step;
        logic cordic_init;
        logic cordic_step;
        logic angle;
        logic mult;
        logic accum;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sqrt_last;
        logic cordic_last;
    } t_status;

    // round(atan(2^-i) * 180/pi * 65536)
    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tas_ctrl.sv @@
`default_nettype none

module tas_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  wire tas_pkg::t_status i_status,
    output tas_pkg::t_cmd        o_cmd
);
    import tas_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // output register can take a new beat
    assign out_free = !r_out_valid || !i_out_stall;

    // state and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_SQUARE;
            ST_SQUARE:    n_state = ST_SQRT_INIT;
            ST_SQRT_INIT: n_state = ST_SQRT;
            ST_SQRT:      if (i_status.sqrt_last) n_state = ST_ROUND;
            ST_ROUND:     n_state = ST_CORDIC;
            ST_CORDIC:    if (i_status.cordic_last) n_state = ST_ANGLE;
            ST_ANGLE:     n_state = ST_MULT;
            ST_MULT:      n_state = ST_ACCUM;
            ST_ACCUM:     n_state = ST_DONE;
            ST_DONE:      if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // commands; input held off while in reset
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall     = !i_rst_n;
                o_cmd.load_in  = i_in_valid && i_rst_n;
            end
            ST_SQUARE:    o_cmd.square      = 1'b1;
            ST_SQRT_INIT: o_cmd.sqrt_init   = 1'b1;
            ST_SQRT:      o_cmd.sqrt_step   = 1'b1;
            ST_ROUND:     o_cmd.cordic_init = 1'b1;
            ST_CORDIC:    o_cmd.cordic_step = 1'b1;
            ST_ANGLE:     o_cmd.angle       = 1'b1;
            ST_MULT:      o_cmd.mult        = 1'b1;
            ST_ACCUM:     o_cmd.accum       = 1'b1;
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/core/tas_datapath.sv @@
`default_nettype none

module tas_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tas_pkg::t_cmd    i_cmd,
    input  wire tas_pkg::t_in     i_in_data,
    input  wire logic [16:0]      i_alpha,
    input  wire logic [14:0]      i_tol,
    output tas_pkg::t_status      o_status,
    output tas_pkg::t_out         o_out_data
);
    import tas_pkg::*;

    localparam logic signed [24:0] ZLim   = 25'(AngleLimit);
    localparam logic signed [24:0] RawLim = 25'(OutLimit);
    localparam logic signed [26:0] AccLim = 27'(AngleLimit);
    localparam logic signed [16:0] SmLim  = 17'(OutLimit);

    // sample and squares
    logic signed [15:0] r_x, r_y, r_z;
    logic [30:0]        r_xx, r_zz;
    logic               r_zero;
    // square root
    logic [61:0]        r_rem, n_rem;
    logic [62:0]        r_q, n_q;
    logic [4:0]         r_cnt;
    // CORDIC
    logic signed [34:0] r_cx, r_cy, n_cx, n_cy;
    logic signed [24:0] r_cz, n_cz;
    // filter
    logic signed [15:0] r_raw, n_raw;
    logic signed [41:0] r_p1, r_p2;
    logic signed [23:0] r_acc, n_acc;
    t_out               r_out, n_out;

    logic signed [31:0] sq_x, sq_z;
    logic [31:0]        sum_s;
    logic [62:0]        bit_v;
    logic [63:0]        trial;
    logic [31:0]        q_rnd;
    logic signed [34:0] dx, dy;
    logic [21:0]        atan_v;
    logic signed [24:0] z_cl, z_rnd, raw_w;
    logic [16:0]        oma;
    logic signed [17:0] oma_s, a_s;
    logic signed [23:0] raw_sc;
    logic signed [42:0] acc_sum;
    logic signed [26:0] acc_sh;
    logic signed [24:0] acc_rnd;
    logic signed [16:0] sm_w;
    logic signed [15:0] sm;
    logic [15:0]        sm_mag;

    // squares of x and z
    assign sq_x  = r_x * r_x;
    assign sq_z  = r_z * r_z;
    assign sum_s = {1'b0, r_xx} + {1'b0, r_zz};

    // one root bit per cycle, trial bit is 4^cnt
    always_comb begin
        bit_v = 63'd1 << {r_cnt, 1'b0};
        trial = {1'b0, r_q} + {1'b0, bit_v};
        if ({2'b00, r_rem} >= trial) begin
            n_rem = r_rem - trial[61:0];
            n_q   = (r_q >> 1) + bit_v;
        end else begin
            n_rem = r_rem;
            n_q   = r_q >> 1;
        end
    end

    // round to nearest
    assign q_rnd = r_q[31:0] + 32'(({2'b00, r_rem} > {1'b0, r_q}));

    // CORDIC vectoring step
    always_comb begin
        dx     = r_cy >>> r_cnt;
        dy     = r_cx >>> r_cnt;
        atan_v = atan_entry(r_cnt);
        if (!r_cy[34]) begin
            n_cx = r_cx + dx;
            n_cy = r_cy - dy;
            n_cz = r_cz + $signed({3'b000, atan_v});
        end else begin
            n_cx = r_cx - dx;
            n_cy = r_cy + dy;
            n_cz = r_cz - $signed({3'b000, atan_v});
        end
    end

    // clamp angle and round to Q7.8
    always_comb begin
        if (r_cz > ZLim)       z_cl = ZLim;
        else if (r_cz < -ZLim) z_cl = -ZLim;
        else                   z_cl = r_cz;
        z_rnd = z_cl + 25'sd128;
        raw_w = z_rnd >>> 8;
        if (raw_w > RawLim)       raw_w = RawLim;
        else if (raw_w < -RawLim) raw_w = -RawLim;
        n_raw = r_zero ? 16'sd0 : raw_w[15:0];
    end

    // filter weights
    assign oma    = 17'd65536 - i_alpha;
    assign oma_s  = $signed({1'b0, oma});
    assign a_s    = $signed({1'b0, i_alpha});
    assign raw_sc = $signed({r_raw, 8'h00});

    // accumulator update
    always_comb begin
        acc_sum = 43'(r_p1) + 43'(r_p2) + 43'sd32768;
        acc_sh  = $signed(acc_sum[42:16]);
        if (acc_sh > AccLim)       acc_sh = AccLim;
        else if (acc_sh < -AccLim) acc_sh = -AccLim;
        n_acc = acc_sh[23:0];
    end

    // smoothed pitch and level test
    always_comb begin
        acc_rnd = 25'(r_acc) + 25'sd128;
        sm_w    = $signed(acc_rnd[24:8]);
        if (sm_w > SmLim)       sm_w = SmLim;
        else if (sm_w < -SmLim) sm_w = -SmLim;
        sm     = sm_w[15:0];
        sm_mag = sm[15] ? 16'(-sm) : 16'(sm);
        n_out.raw_pitch      = r_raw;
        n_out.smoothed_pitch = sm;
        n_out.level_flag     = (sm_mag <= {1'b0, i_tol});
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.accum) begin
            r_acc <= n_acc;
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.sqrt_init) begin
            r_cnt <= 5'd31;
        end else if (i_cmd.sqrt_step) begin
            r_cnt <= r_cnt - 5'd1;
        end else if (i_cmd.cordic_init) begin
            r_cnt <= '0;
        end else if (i_cmd.cordic_step) begin
            r_cnt <= r_cnt + 5'd1;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x <= i_in_data.accel_x;
            r_y <= i_in_data.accel_y;
            r_z <= i_in_data.accel_z;
        end
        if (i_cmd.square) begin
            r_xx <= sq_x[30:0];
            r_zz <= sq_z[30:0];
        end
        if (i_cmd.sqrt_init) begin
            r_rem  <= {sum_s, 30'd0};
            r_q    <= '0;
            r_zero <= (sum_s == 32'd0) && (r_y == 16'sd0);
        end else if (i_cmd.sqrt_step) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
        if (i_cmd.cordic_init) begin
            r_cx <= $signed({3'b000, q_rnd});
            r_cy <= $signed({{4{r_y[15]}}, r_y, 15'd0});
            r_cz <= '0;
        end else if (i_cmd.cordic_step) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cz <= n_cz;
        end
        if (i_cmd.angle) begin
            r_raw <= n_raw;
        end
        if (i_cmd.mult) begin
            r_p1 <= r_acc * oma_s;
            r_p2 <= raw_sc * a_s;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_status.sqrt_last   = (r_cnt == 5'd0);
    assign o_status.cordic_last = (r_cnt == 5'(StepsEff - 1));
    assign o_out_data           = r_out;

endmodule

`default_nettype wire

@@ rtl/core/accel_tilt_angle_smoother_top.sv @@
// Tilt angle smoother: pitch by root and CORDIC vectoring, then exponential filter.
// A sample is taken only from IDLE: the bit-serial square root and the iterative CORDIC
// run to completion first, so the next beat waits for DONE and a free output register.
// Reset (synchronous, active low): idle, no result pending, filter state zero,
// alpha 6554 and tolerance 128. No clearing pass.
`default_nettype none

module accel_tilt_angle_smoother_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire tas_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output tas_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [16:0]   i_cfg_wdata
);
    import tas_pkg::*;

    logic [16:0] r_alpha;
    logic [14:0] r_tol;
    logic [16:0] alpha_eff;
    t_cmd        cmd;
    t_status     status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 17'd6554;
            r_tol   <= 15'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALPHA: r_alpha <= i_cfg_wdata;
                CFG_TOL:   r_tol   <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // weight above 1.0 counts as 1.0
    assign alpha_eff = (r_alpha > 17'd65536) ? 17'd65536 : r_alpha;

    tas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tas_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_alpha    (alpha_eff),
        .i_tol      (r_tol),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

@@ bench/tb_accel_tilt_angle_smoother_top.sv @@
`timescale 1ns / 1ps

module tb_accel_tilt_angle_smoother_top;

    import tas_pkg::*;

    localparam int  HoldCycles = 400;
    localparam int  IdleLimit  = 4000;
    localparam int  TailCycles = 80;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in         i_in_data   = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = CFG_ALPHA;
    logic [16:0] i_cfg_wdata = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out_data;

    accel_tilt_angle_smoother_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // arctangent of 2^-i in degrees, 16 fraction bits
    longint atan_q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // shadow of the block's registers and filter state
    longint unsigned alpha_reg = 6554;
    longint unsigned tol_reg   = 128;
    longint          smooth_acc = 0;

    t_out pitch_q[$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;

    int n_samples    = 0;
    int n_results    = 0;
    int n_level      = 0;
    int n_settings   = 0;
    int n_held_off   = 0;
    int n_mismatch   = 0;

    // clock, 10 ns
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // square root rounded to nearest
    function automatic longint unsigned root_nearest(input longint unsigned n);
        longint unsigned q, bit_w, rem;
        q = 0;
        rem = n;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (rem >= q + bit_w) begin
                rem = rem - (q + bit_w);
                q = (q >> 1) + bit_w;
            end else begin
                q = q >> 1;
            end
            bit_w = bit_w >> 2;
        end
        if (rem > q) q = q + 1;
        return q;
    endfunction

    // pitch in degrees Q.16 by CORDIC vectoring
    function automatic longint tilt_q16(input longint x, input longint y, input longint z);
        longint unsigned mag2;
        longint cx, cy, cz, dx, dy;
        mag2 = longint'(x * x) + longint'(z * z);
        if (mag2 == 0 && y == 0) return 0;
        cx = longint'(root_nearest(mag2 << 30));
        cy = y * 32768;
        cz = 0;
        for (int i = 0; i < StepsEff; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx;
                cy -= dy;
                cz += atan_q16[i];
            end else begin
                cx -= dx;
                cy += dy;
                cz -= atan_q16[i];
            end
        end
        return clamp_sym(cz, AngleLimit);
    endfunction

    // expected result of one sample; advances the shadow filter state
    function automatic t_out smooth_tilt(input t_in s);
        longint raw, a, acc, sm, mag;
        t_out r;
        raw = clamp_sym((tilt_q16(longint'(s.accel_x), longint'(s.accel_y),
                                  longint'(s.accel_z)) + 128) >>> 8, OutLimit);
        a = (alpha_reg > 65536) ? 65536 : longint'(alpha_reg);
        acc = smooth_acc * (65536 - a) + raw * 256 * a + 32768;
        acc = clamp_sym(acc >>> 16, AngleLimit);
        smooth_acc = acc;
        sm = clamp_sym((acc + 128) >>> 8, OutLimit);
        mag = (sm < 0) ? -sm : sm;
        r.raw_pitch      = 16'(raw);
        r.smoothed_pitch = 16'(sm);
        r.level_flag     = (mag <= longint'(tol_reg));
        return r;
    endfunction

    // offer one sample, hold it until taken, then maybe idle
    task automatic send_sample(input t_in s);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_stall);
        pitch_q.push_back(smooth_tilt(s));
        n_samples++;
        gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 70) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_in make_sample(input int x, input int y, input int z);
        t_in s;
        s.accel_x = 16'(x);
        s.accel_y = 16'(y);
        s.accel_z = 16'(z);
        return s;
    endfunction

    // half fully random samples, a quarter near level, a quarter tiny in every axis
    function automatic t_in random_sample();
        t_in s;
        case ($urandom_range(3))
            0, 1: begin
                s = 48'($urandom) ^ (48'($urandom) << 32);
            end
            2: begin
                s = make_sample($urandom_range(0, 4000) - 2000,
                                $urandom_range(0, 600) - 300,
                                $urandom_range(8000, 32767));
                if ($urandom_range(1)) s.accel_z = -s.accel_z;
            end
            default: begin
                s = make_sample($urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8,
                                $urandom_range(0, 15) - 8);
            end
        endcase
        return s;
    endfunction

    // stop offering and wait for every pending result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pitch_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write both registers on consecutive edges; block must be idle
    task automatic set_filter(input logic [16:0] alpha_w, input logic [16:0] tol_w);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ALPHA;
        i_cfg_wdata <= alpha_w;
        @(posedge i_clk);
        alpha_reg = alpha_w;
        i_cfg_index <= CFG_TOL;
        i_cfg_wdata <= tol_w;
        @(posedge i_clk);
        tol_reg = tol_w[14:0];
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // corners of the angle computation under the reset settings
    task automatic test_reset_settings();
        t_in dir_q[$];
        dir_q = '{
            make_sample(0, 0, 0),
            make_sample(0, 32767, 0),
            make_sample(0, -32768, 0),
            make_sample(0, 1, 0),
            make_sample(0, -1, 0),
            make_sample(0, 0, 16384),
            make_sample(-32768, 0, -32768),
            make_sample(32767, 32767, 32767),
            make_sample(-32768, -32768, -32768),
            make_sample(32767, -32768, 0),
            make_sample(1, 1, 1),
            make_sample(-1, 0, 0),
            make_sample(0, 16384, 16384),
            make_sample(16'h5555, 16'shAAAA, 16'h5555)
        };
        foreach (dir_q[i]) send_sample(dir_q[i]);
        drain();
    endtask

    // register extremes: frozen and pass-through filter, clamped alpha,
    // zero tolerance, tolerance beyond full scale, masked upper data bits
    task automatic test_register_extremes();
        set_filter(17'd0, 17'd0);
        send_sample(make_sample(0, 32767, 0));
        send_sample(make_sample(0, 0, 16384));
        drain();
        set_filter(17'd65536, 17'd32767);
        send_sample(make_sample(0, -32768, 0));
        send_sample(make_sample(100, -20000, 3000));
        drain();
        set_filter(17'h1FFFF, 17'h18064);
        send_sample(make_sample(0, 32767, 0));
        send_sample(make_sample(0, 0, 0));
        send_sample(make_sample(0, 20, 16000));
        drain();
        set_filter(17'd1, 17'd23040);
        send_sample(make_sample(0, -32768, 0));
        send_sample(make_sample(0, 32767, 0));
        drain();
    endtask

    // random samples in chunks, new random settings per chunk
    task automatic test_random_traffic(input int chunks, input int per_chunk);
        logic [16:0] alpha_w, tol_w;
        for (int c = 0; c < chunks; c++) begin
            case ($urandom_range(3))
                0: alpha_w = 17'($urandom_range(0, 131071));
                1: alpha_w = ($urandom_range(1)) ? 17'd65536 : 17'd0;
                default: alpha_w = 17'($urandom_range(500, 30000));
            endcase
            tol_w = {2'($urandom), 15'($urandom_range(0, 2000))};
            if ($urandom_range(4) == 0) tol_w[14:0] = 15'($urandom);
            set_filter(alpha_w, tol_w);
            repeat (per_chunk) send_sample(random_sample());
            drain();
        end
    endtask

    // receiver holds off for a long stretch while samples keep coming
    task automatic test_backpressure();
        int keep_snd;
        keep_snd = snd_idle_pct;
        snd_idle_pct = 0;
        hold_req = 1'b1;
        repeat (8) send_sample(random_sample());
        drain();
        snd_idle_pct = keep_snd;
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pitch_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result beat %p", o_out_data);
            end else begin
                want = pitch_q.pop_front();
                if (o_out_data.raw_pitch != want.raw_pitch ||
                    o_out_data.smoothed_pitch != want.smoothed_pitch ||
                    o_out_data.level_flag != want.level_flag) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch at beat %0d: raw %0d/%0d smoothed %0d/%0d level %0b/%0b (exp/act)",
                                 n_results, want.raw_pitch, o_out_data.raw_pitch,
                                 want.smoothed_pitch, o_out_data.smoothed_pitch,
                                 want.level_flag, o_out_data.level_flag);
                end
                if (o_out_data.level_flag) n_level++;
            end
        end
        if (i_rst_n && i_in_valid && o_in_stall && hold_left > 0) n_held_off++;
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // watchdog on cycles with no beat in either direction
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("timeout: no beat for %0d cycles, %0d results pending",
                     idle_cycles, pitch_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int leftover;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_register_extremes();

        snd_idle_pct = 16;
        rcv_idle_pct = 73;
        test_random_traffic(3, 110);
        test_backpressure();

        snd_idle_pct = 73;
        rcv_idle_pct = 16;
        test_random_traffic(3, 110);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_traffic(3, 110);
        test_backpressure();

        repeat (TailCycles) @(posedge i_clk);
        leftover = pitch_q.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);

        $display("Sent %0d samples over %0d filter settings; %0d results, %0d of them level.",
                 n_samples, n_settings, n_results, n_level);
        $display("Sample input held off for %0d cycles during receiver back-pressure.",
                 n_held_off);
        if (n_mismatch == 0 && leftover == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatching beats", n_mismatch);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tas_pkg.sv
rtl/core/tas_ctrl.sv
rtl/core/tas_datapath.sv
rtl/core/accel_tilt_angle_smoother_top.sv
bench/tb_accel_tilt_angle_smoother_top.sv
